@@ rtl/oneshot_and_watchdog_timer_table_top_assert.svh @@
// Assertion macros for the one-shot / watchdog timer table.
// Used by oneshot_and_watchdog_timer_table_top; expects clk_i and rst_ni in scope.
`ifndef ONESHOT_AND_WATCHDOG_TIMER_TABLE_TOP_ASSERT_SVH
`define ONESHOT_AND_WATCHDOG_TIMER_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define OTW_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/otw_pkg.sv @@
// Shared types and constants for the one-shot / watchdog timer table.
// No dependencies.
package otw_pkg;

  localparam int OneshotChannels  = 8;
  localparam int WatchdogChannels = 8;

  typedef enum logic [2:0] {
    MODE_TICK      = 3'd0,
    MODE_OS_START  = 3'd1,
    MODE_OS_CANCEL = 3'd2,
    MODE_OS_SCAN   = 3'd3,
    MODE_WD_START  = 3'd4,
    MODE_WD_FEED   = 3'd5,
    MODE_WD_STOP   = 3'd6,
    MODE_WD_SCAN   = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    KIND_ACCEPTED    = 3'd0,
    KIND_BAD_CHANNEL = 3'd1,
    KIND_OS_FIRED    = 3'd2,
    KIND_WD_FIRED    = 3'd3,
    KIND_SCAN_DONE   = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  chan;
    logic [31:0] now;
    logic        last;
  } res_t;

  // shared add/subtract + compare unit
  typedef struct packed {
    logic        sub;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] limit;
  } cmp_req_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        ge;
  } cmp_rsp_t;

endpackage

@@ rtl/otw_cmp.sv @@
// Shared arithmetic unit: a +/- b, then unsigned compare of the result to a limit.
// Depends on otw_pkg.
module otw_cmp (
  input  otw_pkg::cmp_req_t req_i,
  output otw_pkg::cmp_rsp_t rsp_o
);

  logic [31:0] b_op;
  logic [31:0] sum;

  assign b_op = req_i.sub ? ~req_i.b : req_i.b;
  assign sum  = req_i.a + b_op + {31'd0, req_i.sub};

  assign rsp_o.sum = sum;
  assign rsp_o.ge  = (sum >= req_i.limit);

endmodule

@@ rtl/otw_out_reg.sv @@
// Output register: holds one result word until the sink takes it.
// Depends on otw_pkg.
module otw_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  otw_pkg::res_t       res_i,
  output logic                free_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [39:0]         m_axis_tdata,  // [2:0] fired_channel, [34:3] now_ms
  output logic [2:0]          m_axis_tuser,  // [2:0] kind
  output logic                m_axis_tlast
);

  logic          valid_q;
  otw_pkg::res_t res_q;

  assign free_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && push_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {5'd0, res_q.now, res_q.chan};
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tlast  = res_q.last;

endmodule

@@ rtl/oneshot_and_watchdog_timer_table_top.sv @@
// Tick, start, cancel, feed, stop: word accepted, then its result is pushed into the output
// register once the register is free; no new word is taken until then.
// Scan: one cycle per channel through the shared add/compare unit, unless a fired word waits
// for the output register, then the done word; the next word waits until that word is pushed.
// Reset (async, active low) clears the ms counter, active bits and feed times; expiry and
// period entries are undefined until a start writes them.
`include "oneshot_and_watchdog_timer_table_top_assert.svh"

module oneshot_and_watchdog_timer_table_top #(
  parameter int ONESHOT_CHANNELS  = otw_pkg::OneshotChannels,
  parameter int WATCHDOG_CHANNELS = otw_pkg::WatchdogChannels
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [3:0] channel, [35:4] duration_ms
  input  logic [2:0]  s_axis_tuser,   // [2:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [2:0] fired_channel, [34:3] now_ms
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast
);

  localparam int OS_IW = (ONESHOT_CHANNELS > 1) ? $clog2(ONESHOT_CHANNELS) : 1;
  localparam int WD_IW = (WATCHDOG_CHANNELS > 1) ? $clog2(WATCHDOG_CHANNELS) : 1;
  localparam int IDX_W = (OS_IW > WD_IW) ? OS_IW : WD_IW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e                       state_q;
  otw_pkg::mode_e               mode_q;
  logic [3:0]                   chan_q;
  logic [31:0]                  dur_q;
  logic [IDX_W-1:0]             idx_q;
  logic [31:0]                  ms_q;
  logic [ONESHOT_CHANNELS-1:0]  os_act_q;
  logic [WATCHDOG_CHANNELS-1:0] wd_act_q;
  logic [31:0]                  os_exp_q  [ONESHOT_CHANNELS];
  logic [31:0]                  wd_per_q  [WATCHDOG_CHANNELS];
  logic [31:0]                  wd_feed_q [WATCHDOG_CHANNELS];

  otw_pkg::cmp_req_t req;
  otw_pkg::cmp_rsp_t rsp;
  otw_pkg::res_t     res;
  logic              push;
  logic              out_free;
  logic [OS_IW-1:0]  idx_os;
  logic [WD_IW-1:0]  idx_wd;
  logic              os_ok;
  logic              wd_ok;
  logic              os_scan;
  logic              scan_fire;
  logic              idx_end;
  logic              exec_go;

  assign idx_os  = idx_q[OS_IW-1:0];
  assign idx_wd  = idx_q[WD_IW-1:0];
  assign os_ok   = {28'd0, chan_q} < 32'(ONESHOT_CHANNELS);
  assign wd_ok   = {28'd0, chan_q} < 32'(WATCHDOG_CHANNELS);
  assign os_scan = (mode_q == otw_pkg::MODE_OS_SCAN);
  assign idx_end = os_scan ? (idx_q == IDX_W'(ONESHOT_CHANNELS - 1))
                           : (idx_q == IDX_W'(WATCHDOG_CHANNELS - 1));
  assign exec_go = (state_q == ST_EXEC) && out_free;

  // one-shot fires when now - expiry is not negative; watchdog when elapsed >= period
  assign scan_fire = os_scan ? (os_act_q[idx_os] && !rsp.sum[31])
                             : (wd_act_q[idx_wd] && rsp.ge);

  assign s_axis_tready = (state_q == ST_IDLE);

  otw_cmp u_cmp (
    .req_i (req),
    .rsp_o (rsp)
  );

  always_comb begin
    req       = '0;
    req.a     = ms_q;
    req.b     = dur_q;
    push      = 1'b0;
    res.kind  = otw_pkg::KIND_ACCEPTED;
    res.chan  = 3'd0;
    res.now   = ms_q;
    res.last  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
      end
      ST_EXEC: begin
        if (mode_q == otw_pkg::MODE_TICK) begin
          req.b   = 32'd1;
          res.now = rsp.sum;
        end
        if ((mode_q == otw_pkg::MODE_OS_START && !os_ok) ||
            (mode_q == otw_pkg::MODE_WD_START && !wd_ok)) begin
          res.kind = otw_pkg::KIND_BAD_CHANNEL;
        end
        res.last = 1'b1;
        push     = out_free;
      end
      ST_SCAN: begin
        req.sub = 1'b1;
        if (os_scan) begin
          req.b    = os_exp_q[idx_os];
          res.kind = otw_pkg::KIND_OS_FIRED;
        end else begin
          req.b     = wd_feed_q[idx_wd];
          req.limit = wd_per_q[idx_wd];
          res.kind  = otw_pkg::KIND_WD_FIRED;
        end
        res.chan = 3'(idx_q);
        push     = scan_fire && out_free;
      end
      ST_DONE: begin
        res.kind = otw_pkg::KIND_SCAN_DONE;
        res.last = 1'b1;
        push     = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mode_q   <= otw_pkg::MODE_TICK;
      chan_q   <= '0;
      dur_q    <= '0;
      idx_q    <= '0;
      ms_q     <= '0;
      os_act_q <= '0;
      wd_act_q <= '0;
      for (int i = 0; i < WATCHDOG_CHANNELS; i++) begin
        wd_feed_q[i] <= '0;
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            mode_q  <= otw_pkg::mode_e'(s_axis_tuser);
            chan_q  <= s_axis_tdata[3:0];
            dur_q   <= s_axis_tdata[35:4];
            idx_q   <= '0;
            state_q <= (s_axis_tuser == otw_pkg::MODE_OS_SCAN ||
                        s_axis_tuser == otw_pkg::MODE_WD_SCAN) ? ST_SCAN : ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            state_q <= ST_IDLE;
            unique case (mode_q)
              otw_pkg::MODE_TICK: begin
                ms_q <= rsp.sum;
              end
              otw_pkg::MODE_OS_START, otw_pkg::MODE_OS_CANCEL: begin
                for (int i = 0; i < ONESHOT_CHANNELS; i++) begin
                  if (os_ok && 32'(chan_q) == i) begin
                    os_act_q[i] <= (mode_q == otw_pkg::MODE_OS_START);
                  end
                end
              end
              otw_pkg::MODE_WD_START, otw_pkg::MODE_WD_FEED, otw_pkg::MODE_WD_STOP: begin
                for (int i = 0; i < WATCHDOG_CHANNELS; i++) begin
                  if (wd_ok && 32'(chan_q) == i) begin
                    if (mode_q != otw_pkg::MODE_WD_FEED) begin
                      wd_act_q[i] <= (mode_q == otw_pkg::MODE_WD_START);
                    end
                    if (mode_q != otw_pkg::MODE_WD_STOP) begin
                      wd_feed_q[i] <= ms_q;
                    end
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (!scan_fire || out_free) begin
            if (scan_fire) begin
              if (os_scan) begin
                os_act_q[idx_os] <= 1'b0;
              end else begin
                wd_feed_q[idx_wd] <= ms_q;   // re-arm from now
              end
            end
            if (idx_end) begin
              state_q <= ST_DONE;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // expiry and period: written only by a start, never reset
  always_ff @(posedge clk_i) begin
    if (exec_go && mode_q == otw_pkg::MODE_OS_START) begin
      for (int i = 0; i < ONESHOT_CHANNELS; i++) begin
        if (os_ok && 32'(chan_q) == i) begin
          os_exp_q[i] <= rsp.sum;
        end
      end
    end
    if (exec_go && mode_q == otw_pkg::MODE_WD_START) begin
      for (int i = 0; i < WATCHDOG_CHANNELS; i++) begin
        if (wd_ok && 32'(chan_q) == i) begin
          wd_per_q[i] <= dur_q;
        end
      end
    end
  end

  otw_out_reg u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .res_i         (res),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  `OTW_ASSERT_NEXT(a_ms_only_on_tick,
    !(exec_go && mode_q == otw_pkg::MODE_TICK), $stable(ms_q),
    "ms counter moved without a tick")
  `OTW_ASSERT_NEXT(a_os_scan_no_arm,
    state_q == ST_SCAN && os_scan, $countones(os_act_q) <= $past($countones(os_act_q)),
    "one-shot armed during scan")
  `OTW_ASSERT_NEXT(a_last_ends_item,
    push && res.last, state_q == ST_IDLE,
    "last word pushed but item not finished")
  `OTW_ASSERT(a_chan_zero_unless_fired,
    push && res.kind != otw_pkg::KIND_OS_FIRED && res.kind != otw_pkg::KIND_WD_FIRED,
    res.chan == 3'd0,
    "nonzero channel on non-fired word")

endmodule

@@ tb/oneshot_and_watchdog_timer_table_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for oneshot_and_watchdog_timer_table_top: directed and random command words,
// and an in-bench timer table predictor that checks every result word in order.
// Depends on otw_pkg and the top-level RTL only.
module oneshot_and_watchdog_timer_table_top_test;

  localparam int ClkHalf       = 6;
  localparam int CycleLimit    = 500000;
  localparam int WordsPerPhase = 65;
  localparam int HoldCycles    = 400;
  localparam int TailCycles    = 24;

  typedef struct {
    otw_pkg::mode_e mode;
    logic [3:0]     chan;
    logic [31:0]    dur;
  } timer_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // [3:0] channel, [35:4] duration_ms
  logic [2:0]  s_axis_tuser = '0;   // [2:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [2:0] fired_channel, [34:3] now_ms
  logic [2:0]  m_axis_tuser;        // [2:0] kind
  logic        m_axis_tlast;

  oneshot_and_watchdog_timer_table_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // predicted block state
  logic [31:0] now_ms;
  logic        os_on     [otw_pkg::OneshotChannels];
  logic [31:0] os_due    [otw_pkg::OneshotChannels];
  logic        wd_on     [otw_pkg::WatchdogChannels];
  logic [31:0] wd_period [otw_pkg::WatchdogChannels];
  logic [31:0] wd_fed    [otw_pkg::WatchdogChannels];

  timer_cmd_t    cmds_to_send[$];
  timer_cmd_t    next_cmd;
  otw_pkg::res_t results_due[$];
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;
  int            hold_left      = 0;
  int            errors         = 0;
  int            cycles         = 0;

  initial begin
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  task automatic push_result(input otw_pkg::kind_e k, input int ch, input logic is_last);
    otw_pkg::res_t r;
    r.kind = k;
    r.chan = ch[2:0];
    r.now  = now_ms;
    r.last = is_last;
    results_due.push_back(r);
  endtask

  // one accepted command word: update the table and queue its result words
  task automatic timer_table_step(input otw_pkg::mode_e md, input logic [3:0] ch,
                                  input logic [31:0] dur);
    otw_pkg::kind_e k;
    logic [31:0]    diff;
    k = otw_pkg::KIND_ACCEPTED;
    case (md)
      otw_pkg::MODE_TICK: now_ms = now_ms + 32'd1;
      otw_pkg::MODE_OS_START: begin
        if (ch < otw_pkg::OneshotChannels) begin
          os_on[ch]  = 1'b1;
          os_due[ch] = now_ms + dur;
        end else begin
          k = otw_pkg::KIND_BAD_CHANNEL;
        end
      end
      otw_pkg::MODE_OS_CANCEL: if (ch < otw_pkg::OneshotChannels) os_on[ch] = 1'b0;
      otw_pkg::MODE_OS_SCAN: begin
        for (int i = 0; i < otw_pkg::OneshotChannels; i++) begin
          diff = now_ms - os_due[i];
          // fires once the signed distance to expiry is not negative
          if (os_on[i] && !diff[31]) begin
            os_on[i] = 1'b0;
            push_result(otw_pkg::KIND_OS_FIRED, i, 1'b0);
          end
        end
        k = otw_pkg::KIND_SCAN_DONE;
      end
      otw_pkg::MODE_WD_START: begin
        if (ch < otw_pkg::WatchdogChannels) begin
          wd_on[ch]     = 1'b1;
          wd_period[ch] = dur;
          wd_fed[ch]    = now_ms;
        end else begin
          k = otw_pkg::KIND_BAD_CHANNEL;
        end
      end
      otw_pkg::MODE_WD_FEED: if (ch < otw_pkg::WatchdogChannels) wd_fed[ch] = now_ms;
      otw_pkg::MODE_WD_STOP: if (ch < otw_pkg::WatchdogChannels) wd_on[ch] = 1'b0;
      default: begin
        for (int i = 0; i < otw_pkg::WatchdogChannels; i++) begin
          if (wd_on[i] && (now_ms - wd_fed[i]) >= wd_period[i]) begin
            push_result(otw_pkg::KIND_WD_FIRED, i, 1'b0);
            wd_fed[i] = now_ms;
          end
        end
        k = otw_pkg::KIND_SCAN_DONE;
      end
    endcase
    push_result(k, 0, 1'b1);
  endtask

  task automatic queue_cmd(input otw_pkg::mode_e md, input int ch, input logic [31:0] dur);
    timer_cmd_t c;
    c.mode = md;
    c.chan = ch[3:0];
    c.dur  = dur;
    cmds_to_send.push_back(c);
  endtask

  // mostly short delays and in-range channels so that channels actually fire
  function automatic timer_cmd_t random_cmd(input logic scan_heavy);
    timer_cmd_t c;
    int         r;
    r = $urandom_range(99);
    c.chan = ($urandom_range(7) == 0) ? 4'($urandom_range(15, 8)) : 4'($urandom_range(7));
    case ($urandom_range(9))
      7: c.dur = $urandom;
      8: begin
        case ($urandom_range(3))
          0: c.dur = 32'h7FFF_FFFF;
          1: c.dur = 32'h8000_0000;
          2: c.dur = 32'h8000_0001;
          default: c.dur = 32'hFFFF_FFFF;
        endcase
      end
      9: c.dur = 32'($urandom_range(40));
      default: c.dur = 32'($urandom_range(6));
    endcase
    if (scan_heavy && $urandom_range(1))
      c.mode = $urandom_range(1) ? otw_pkg::MODE_OS_SCAN : otw_pkg::MODE_WD_SCAN;
    else if (r < 34) c.mode = otw_pkg::MODE_TICK;
    else if (r < 47) c.mode = otw_pkg::MODE_OS_START;
    else if (r < 52) c.mode = otw_pkg::MODE_OS_CANCEL;
    else if (r < 64) c.mode = otw_pkg::MODE_OS_SCAN;
    else if (r < 74) c.mode = otw_pkg::MODE_WD_START;
    else if (r < 82) c.mode = otw_pkg::MODE_WD_FEED;
    else if (r < 86) c.mode = otw_pkg::MODE_WD_STOP;
    else c.mode = otw_pkg::MODE_WD_SCAN;
    return c;
  endfunction

  task automatic wait_drained();
    while (cmds_to_send.size() > 0 || s_axis_tvalid || results_due.size() > 0)
      @(negedge clk_i);
  endtask

  // sender
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        timer_table_step(otw_pkg::mode_e'(s_axis_tuser), s_axis_tdata[3:0],
                         s_axis_tdata[35:4]);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmds_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_cmd = cmds_to_send.pop_front();
          s_axis_tdata  <= {4'b0, next_cmd.dur, next_cmd.chan};
          s_axis_tuser  <= next_cmd.mode;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver, with an optional long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result word: kind %0d chan %0d now %0d last %0d",
               m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[34:3], m_axis_tlast);
        errors++;
      end else begin
        if (m_axis_tuser !== results_due[0].kind) begin
          $error("kind: expected %0d, got %0d", results_due[0].kind, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[2:0] !== results_due[0].chan) begin
          $error("fired_channel: expected %0d, got %0d", results_due[0].chan, m_axis_tdata[2:0]);
          errors++;
        end
        if (m_axis_tdata[34:3] !== results_due[0].now) begin
          $error("now_ms: expected %0d, got %0d", results_due[0].now, m_axis_tdata[34:3]);
          errors++;
        end
        if (m_axis_tlast !== results_due[0].last) begin
          $error("last: expected %0d, got %0d", results_due[0].last, m_axis_tlast);
          errors++;
        end
        void'(results_due.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    now_ms = '0;
    for (int i = 0; i < otw_pkg::OneshotChannels; i++) begin
      os_on[i]  = 1'b0;
      os_due[i] = '0;
    end
    for (int i = 0; i < otw_pkg::WatchdogChannels; i++) begin
      wd_on[i]     = 1'b0;
      wd_period[i] = '0;
      wd_fed[i]    = '0;
    end
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty scan, bounds, wrap of expiry sign, cancel, restart, zero period
    queue_cmd(otw_pkg::MODE_OS_SCAN,   0,  32'd0);
    queue_cmd(otw_pkg::MODE_OS_START,  0,  32'd0);
    queue_cmd(otw_pkg::MODE_OS_START,  7,  32'd1);
    queue_cmd(otw_pkg::MODE_OS_START,  8,  32'd5);
    queue_cmd(otw_pkg::MODE_OS_START,  15, 32'hFFFF_FFFF);
    queue_cmd(otw_pkg::MODE_OS_START,  3,  32'h8000_0000);
    queue_cmd(otw_pkg::MODE_OS_START,  4,  32'h7FFF_FFFF);
    queue_cmd(otw_pkg::MODE_OS_SCAN,   0,  32'd0);
    queue_cmd(otw_pkg::MODE_TICK,      0,  32'd0);
    queue_cmd(otw_pkg::MODE_OS_SCAN,   0,  32'd0);
    queue_cmd(otw_pkg::MODE_OS_START,  5,  32'd2);
    queue_cmd(otw_pkg::MODE_OS_CANCEL, 5,  32'd0);
    queue_cmd(otw_pkg::MODE_OS_CANCEL, 12, 32'd0);
    queue_cmd(otw_pkg::MODE_OS_START,  1,  32'd100);
    queue_cmd(otw_pkg::MODE_OS_START,  1,  32'd0);
    queue_cmd(otw_pkg::MODE_OS_SCAN,   0,  32'd0);
    queue_cmd(otw_pkg::MODE_WD_START,  0,  32'd0);
    queue_cmd(otw_pkg::MODE_WD_START,  7,  32'hFFFF_FFFF);
    queue_cmd(otw_pkg::MODE_WD_START,  8,  32'd3);
    queue_cmd(otw_pkg::MODE_WD_START,  15, 32'd3);
    queue_cmd(otw_pkg::MODE_WD_FEED,   2,  32'd0);
    queue_cmd(otw_pkg::MODE_WD_FEED,   9,  32'd0);
    queue_cmd(otw_pkg::MODE_WD_STOP,   10, 32'd0);
    queue_cmd(otw_pkg::MODE_WD_START,  2,  32'd1);
    queue_cmd(otw_pkg::MODE_WD_SCAN,   0,  32'd0);
    queue_cmd(otw_pkg::MODE_TICK,      0,  32'd0);
    queue_cmd(otw_pkg::MODE_WD_SCAN,   0,  32'd0);
    queue_cmd(otw_pkg::MODE_WD_STOP,   0,  32'd0);
    queue_cmd(otw_pkg::MODE_WD_SCAN,   0,  32'd0);

    // random phases: no idling, sender idle, receiver stalls, both
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = (p == 1) ? 84 : (p == 3) ? 38 : 0;
      recv_stall_pct = (p == 2) ? 84 : (p == 3) ? 38 : 0;
      for (int n = 0; n < WordsPerPhase; n++) cmds_to_send.push_back(random_cmd(1'b0));
      wait_drained();
    end

    // back-pressure: receiver held off while scans keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = HoldCycles;
    for (int n = 0; n < 40; n++) cmds_to_send.push_back(random_cmd(1'b1));
    wait_drained();

    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
